FILE: design/bsc_pkg.sv
// shared types, constants and codes for the sine commutation block
package bsc_pkg;

	localparam int SINE_DEPTH_DEF = 256;
	localparam int DUTY_LIMIT_DEF = 31;

	localparam logic [2:0] REG_MODE     = 3'd0;
	localparam logic [2:0] REG_PERCENT  = 3'd1;
	localparam logic [2:0] REG_TPOS     = 3'd2;
	localparam logic [2:0] REG_TELEC    = 3'd3;
	localparam logic [2:0] REG_GAIN     = 3'd4;
	localparam logic [2:0] REG_POLES    = 3'd5;

	localparam logic [2:0] MODE_IDLE       = 3'd0;
	localparam logic [2:0] MODE_OPEN_PCT   = 3'd1;
	localparam logic [2:0] MODE_CLOSED_PCT = 3'd2;
	localparam logic [2:0] MODE_OPEN_POS   = 3'd3;
	localparam logic [2:0] MODE_CLOSED_POS = 3'd4;

	localparam int MUL_AW = 33;
	localparam int MUL_BW = 23;
	localparam int MUL_PW = MUL_AW + MUL_BW;

	localparam logic [22:0] K_POS_GAIN    = 23'd1448;
	localparam logic [22:0] K_POS_ERR     = 23'd39322;
	localparam logic [22:0] K_STEP_TGT    = 23'd2670;
	localparam logic [22:0] K_TORQUE_TGT  = 23'd33554;
	localparam logic [22:0] K_TORQUE_RAMP = 23'd197;
	localparam logic [22:0] K_AMP_STEP    = 23'd617661;
	localparam logic [22:0] K_RECIP45     = 23'd5965233;
	localparam logic [22:0] K_WRAP        = 23'd184320;
	localparam int          RECIP_SHIFT   = 28;

	localparam logic [15:0] OFFSET_V = 16'd21845;
	localparam logic [15:0] OFFSET_W = 16'd43691;

	typedef enum logic [4:0] {
		S_IDLE, S_P, S_PC, S_T, S_TC, S_R, S_RC, S_A, S_AC,
		S_E, S_EC, S_Q, S_QC, S_QM, S_QMC, S_D, S_DC,
		S_SP, S_SPC, S_DU, S_DUC, S_OUT
	} state_t;

endpackage

FILE: design/bldc_sine_commutation_step.sv
// top level: sinusoidal three-phase commutation, one control tick per transaction
//
// channel  dir  handshake            payload
// input    in   in_valid/in_stall    encoder_angle
// output   out  out_valid/out_stall  u_duty v_duty w_duty drive_enable duty_rejected
// config   in   wr_en                wr_index wr_data
//
// one transaction at a time through a single shared multiplier with a registered product
// acceptance to result: idle mode goes straight to the result, the other modes run the multiply sequence
// after the result is taken the block returns to idle before the next input is accepted
// in_stall stays high from acceptance until the result is taken
// reset clears configuration to defaults and the control state to zero; datapath work registers are not reset
module bldc_sine_commutation_step #(
	parameter int SINE_TABLE_DEPTH  = bsc_pkg::SINE_DEPTH_DEF,
	parameter int SAFETY_DUTY_LIMIT = bsc_pkg::DUTY_LIMIT_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               wr_en,
	input  logic [2:0]         wr_index,
	input  logic [31:0]        wr_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [23:0] encoder_angle,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [12:0]        u_duty,
	output logic [12:0]        v_duty,
	output logic [12:0]        w_duty,
	output logic               drive_enable,
	output logic               duty_rejected
);

	localparam int KW = $clog2(SINE_TABLE_DEPTH + 1);
	localparam int PW = $clog2(4 * SINE_TABLE_DEPTH);
	localparam logic [16:0] LIMIT_Q8 = 17'(SAFETY_DUTY_LIMIT * 256);
	localparam logic [22:0] POS_SCALE = 23'(4 * SINE_TABLE_DEPTH);
	localparam logic [PW-1:0] D1 = PW'(SINE_TABLE_DEPTH);
	localparam logic [PW-1:0] D2 = PW'(2 * SINE_TABLE_DEPTH);
	localparam logic [PW-1:0] D3 = PW'(3 * SINE_TABLE_DEPTH);
	localparam logic [63:0] Q30_ONE = 64'd1073741824;
	localparam logic [63:0] Q30_HALF_PI = 64'd1686629713;

	// quarter-wave sine table
	logic [15:0] sin_tab [SINE_TABLE_DEPTH+1];
	for (genvar gi = 0; gi <= SINE_TABLE_DEPTH; gi++) begin : g_tab
		localparam logic [63:0] X  = 64'(gi) * Q30_HALF_PI / SINE_TABLE_DEPTH;
		localparam logic [63:0] X2 = (X * X) >> 30;
		localparam logic [63:0] T1 = Q30_ONE - ((X2 * Q30_ONE) >> 30) / 110;
		localparam logic [63:0] T2 = Q30_ONE - ((X2 * T1) >> 30) / 72;
		localparam logic [63:0] T3 = Q30_ONE - ((X2 * T2) >> 30) / 42;
		localparam logic [63:0] T4 = Q30_ONE - ((X2 * T3) >> 30) / 20;
		localparam logic [63:0] T5 = Q30_ONE - ((X2 * T4) >> 30) / 6;
		localparam logic [63:0] SV = (X * T5) >> 30;
		localparam logic [63:0] EV = (SV * 64'd32767 + 64'd536870912) >> 30;
		assign sin_tab[gi] = EV[15:0];
	end

	bsc_pkg::state_t state_q, state_d;

	logic [2:0]         mode_q;
	logic signed [15:0] pct_q;
	logic signed [23:0] tpos_q;
	logic signed [31:0] telec_q;
	logic [15:0]        gain_q;
	logic [6:0]         poles_q;

	logic [31:0]        ang_q;
	logic signed [17:0] step_q;
	logic signed [15:0] torque_q;
	logic [12:0]        held_q [3];
	logic               drive_q;
	logic               rej_q;

	logic signed [23:0] enc_q;
	logic signed [15:0] p_q;
	logic signed [17:0] tgt_q;
	logic [17:0]        amp_q;
	logic [15:0]        phase_q;
	logic signed [15:0] s_q;
	logic [12:0]        d_q [2];
	logic [1:0]         j_q;
	logic               aneg_q;
	logic [31:0]        ma_q;
	logic [12:0]        quo_q;
	logic [17:0]        r_q;
	logic               neg_q;

	logic [bsc_pkg::MUL_AW-1:0] mul_a;
	logic [bsc_pkg::MUL_BW-1:0] mul_b;
	logic                       mul_neg;
	logic [bsc_pkg::MUL_PW-1:0] prod;

	bsc_mul u_mul (
		.clk  (clk),
		.a    (mul_a),
		.b    (mul_b),
		.prod (prod)
	);

	function automatic logic signed [40:0] rshr16(input logic [bsc_pkg::MUL_PW-1:0] pr,
			input logic ng);
		logic [bsc_pkg::MUL_PW-1:0] t;
		logic signed [40:0] m;
		t = (pr + bsc_pkg::MUL_PW'(32768)) >> 16;
		m = $signed(t[40:0]);
		return ng ? -m : m;
	endfunction

	logic open_w, idle_w;
	assign open_w = (mode_q == bsc_pkg::MODE_OPEN_PCT) || (mode_q == bsc_pkg::MODE_OPEN_POS);
	assign idle_w = (mode_q == bsc_pkg::MODE_IDLE) || (mode_q > bsc_pkg::MODE_CLOSED_POS);

	logic signed [32:0] diff3;
	logic signed [24:0] e4;
	logic signed [18:0] cur19, rdiff;
	logic signed [40:0] r16;
	logic [15:0]        off_j;
	logic signed [22:0] base;
	assign diff3 = $signed({telec_q[31], telec_q}) - $signed({ang_q[31], ang_q});
	assign e4    = $signed({tpos_q[23], tpos_q}) - $signed({enc_q[23], enc_q});
	assign cur19 = open_w ? 19'(step_q) : 19'(torque_q);
	assign rdiff = 19'(tgt_q) - cur19;
	assign r16   = rshr16(prod, neg_q);
	assign off_j = (j_q == 2'd1) ? bsc_pkg::OFFSET_V :
		((j_q == 2'd2) ? bsc_pkg::OFFSET_W : 16'd0);
	assign base  = 23'(s_q) * 23'sd50 + 23'sd1638400;

	// percent command selection and clamp
	logic signed [40:0] pv, pcl;
	always_comb begin
		if (mode_q == bsc_pkg::MODE_OPEN_POS) begin
			pv = r16;
		end else if (mode_q == bsc_pkg::MODE_CLOSED_POS) begin
			pv = r16 + ((prod == '0) ? 41'sd0 : (neg_q ? -41'sd256 : 41'sd256));
		end else begin
			pv = 41'(pct_q);
		end
		if (pv > 41'sd25600) pcl = 41'sd25600;
		else if (pv < -41'sd25600) pcl = -41'sd25600;
		else pcl = pv;
	end

	// ramp update with snap to target
	logic signed [19:0] nv, nrem, ramp_new;
	logic [19:0]        nabs;
	always_comb begin
		nv   = 20'(cur19) + 20'(r16);
		nrem = 20'(tgt_q) - nv;
		nabs = nrem[19] ? 20'(-nrem) : 20'(nrem);
		if (nabs <= (open_w ? 20'd104 : 20'd655)) ramp_new = 20'(tgt_q);
		else ramp_new = nv;
	end

	logic [31:0] ang_open;
	assign ang_open = ang_q + 32'(ramp_new);

	// closed-loop angle pieces
	logic signed [32:0] a_sp, a_w;
	logic [16:0]        turns;
	logic [31:0]        ang_cl;
	logic [15:0]        phase_cl;
	assign a_sp     = neg_q ? -$signed(prod[32:0]) : $signed(prod[32:0]);
	assign a_w      = a_sp - 33'sd46080;
	assign turns    = prod[bsc_pkg::RECIP_SHIFT +: 17];
	assign ang_cl   = aneg_q ? -32'(turns) : 32'(turns);
	assign phase_cl = ang_cl[15:0] + ((torque_q >= 0) ? 16'd16384 : 16'd49152);

	// sine lookup
	logic [PW-1:0] pos;
	logic [1:0]    quad;
	logic [PW-1:0] kpos;
	logic [KW-1:0] kidx;
	logic [15:0]   tval;
	always_comb begin
		pos = prod[16 +: PW];
		if (pos >= D3) begin
			quad = 2'd3;
			kpos = pos - D3;
		end else if (pos >= D2) begin
			quad = 2'd2;
			kpos = pos - D2;
		end else if (pos >= D1) begin
			quad = 2'd1;
			kpos = pos - D1;
		end else begin
			quad = 2'd0;
			kpos = pos;
		end
		kidx = quad[0] ? KW'(D1 - kpos) : KW'(kpos);
		tval = sin_tab[kidx];
	end

	logic [16:0] duty_new;
	logic        rej_new;
	assign duty_new = 17'((prod + bsc_pkg::MUL_PW'(4194304)) >> 23);
	assign rej_new  = duty_new >= LIMIT_Q8;

	// next state and multiplier operands
	always_comb begin
		state_d = state_q;
		mul_a   = '0;
		mul_b   = '0;
		mul_neg = 1'b0;
		case (state_q)
			bsc_pkg::S_IDLE: begin
				if (in_valid) state_d = idle_w ? bsc_pkg::S_OUT : bsc_pkg::S_P;
			end
			bsc_pkg::S_P: begin
				if (mode_q == bsc_pkg::MODE_OPEN_POS) begin
					mul_a   = diff3[32] ? 33'(-diff3) : 33'(diff3);
					mul_neg = diff3[32];
					mul_b   = bsc_pkg::K_POS_GAIN;
				end else begin
					mul_a   = e4[24] ? 33'(-e4) : 33'(e4);
					mul_neg = e4[24];
					mul_b   = bsc_pkg::K_POS_ERR;
				end
				state_d = bsc_pkg::S_PC;
			end
			bsc_pkg::S_PC: state_d = bsc_pkg::S_T;
			bsc_pkg::S_T: begin
				mul_a   = p_q[15] ? 33'(-p_q) : 33'(p_q);
				mul_neg = p_q[15];
				mul_b   = open_w ? bsc_pkg::K_STEP_TGT : bsc_pkg::K_TORQUE_TGT;
				state_d = bsc_pkg::S_TC;
			end
			bsc_pkg::S_TC: state_d = bsc_pkg::S_R;
			bsc_pkg::S_R: begin
				mul_a   = rdiff[18] ? 33'(-rdiff) : 33'(rdiff);
				mul_neg = rdiff[18];
				mul_b   = open_w ? 23'(gain_q) : bsc_pkg::K_TORQUE_RAMP;
				state_d = bsc_pkg::S_RC;
			end
			bsc_pkg::S_RC: state_d = open_w ? bsc_pkg::S_A : bsc_pkg::S_E;
			bsc_pkg::S_A: begin
				mul_a   = step_q[17] ? 33'(-step_q) : 33'(step_q);
				mul_b   = bsc_pkg::K_AMP_STEP;
				state_d = bsc_pkg::S_AC;
			end
			bsc_pkg::S_AC: state_d = bsc_pkg::S_SP;
			bsc_pkg::S_E: begin
				mul_a   = enc_q[23] ? 33'(-enc_q) : 33'(enc_q);
				mul_neg = enc_q[23];
				mul_b   = 23'(poles_q);
				state_d = bsc_pkg::S_EC;
			end
			bsc_pkg::S_EC: state_d = bsc_pkg::S_Q;
			bsc_pkg::S_Q: begin
				mul_a   = 33'(ma_q >> 12);
				mul_b   = bsc_pkg::K_RECIP45;
				state_d = bsc_pkg::S_QC;
			end
			bsc_pkg::S_QC: state_d = bsc_pkg::S_QM;
			bsc_pkg::S_QM: begin
				mul_a   = 33'(quo_q);
				mul_b   = bsc_pkg::K_WRAP;
				state_d = bsc_pkg::S_QMC;
			end
			bsc_pkg::S_QMC: state_d = bsc_pkg::S_D;
			bsc_pkg::S_D: begin
				mul_a   = 33'(r_q) * 33'd16 + 33'd22;
				mul_b   = bsc_pkg::K_RECIP45;
				state_d = bsc_pkg::S_DC;
			end
			bsc_pkg::S_DC: state_d = bsc_pkg::S_SP;
			bsc_pkg::S_SP: begin
				mul_a   = 33'(16'(phase_q + off_j));
				mul_b   = POS_SCALE;
				state_d = bsc_pkg::S_SPC;
			end
			bsc_pkg::S_SPC: state_d = bsc_pkg::S_DU;
			bsc_pkg::S_DU: begin
				mul_a   = 33'(unsigned'(base));
				mul_b   = 23'(amp_q);
				state_d = bsc_pkg::S_DUC;
			end
			bsc_pkg::S_DUC: state_d = (j_q == 2'd2) ? bsc_pkg::S_OUT : bsc_pkg::S_SP;
			bsc_pkg::S_OUT: begin
				if (!out_stall) state_d = bsc_pkg::S_IDLE;
			end
			default: state_d = bsc_pkg::S_IDLE;
		endcase
	end

	assign in_stall  = (state_q != bsc_pkg::S_IDLE);
	assign out_valid = (state_q == bsc_pkg::S_OUT);
	assign u_duty        = held_q[0];
	assign v_duty        = held_q[1];
	assign w_duty        = held_q[2];
	assign drive_enable  = drive_q;
	assign duty_rejected = rej_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= bsc_pkg::S_IDLE;
			mode_q    <= bsc_pkg::MODE_IDLE;
			pct_q     <= '0;
			tpos_q    <= '0;
			telec_q   <= '0;
			gain_q    <= 16'd6554;
			poles_q   <= 7'd14;
			ang_q     <= '0;
			step_q    <= '0;
			torque_q  <= '0;
			held_q[0] <= '0;
			held_q[1] <= '0;
			held_q[2] <= '0;
			drive_q   <= 1'b0;
			rej_q     <= 1'b0;
			j_q       <= '0;
		end else begin
			state_q <= state_d;
			if (wr_en) begin
				case (wr_index)
					bsc_pkg::REG_MODE:    mode_q  <= wr_data[2:0];
					bsc_pkg::REG_PERCENT: pct_q   <= wr_data[15:0];
					bsc_pkg::REG_TPOS:    tpos_q  <= wr_data[23:0];
					bsc_pkg::REG_TELEC:   telec_q <= wr_data;
					bsc_pkg::REG_GAIN:    gain_q  <= wr_data[15:0];
					bsc_pkg::REG_POLES:   poles_q <= wr_data[6:0];
					default: ;
				endcase
			end
			case (state_q)
				bsc_pkg::S_IDLE: begin
					if (in_valid) begin
						rej_q   <= 1'b0;
						j_q     <= '0;
						drive_q <= !idle_w;
						if (idle_w) begin
							step_q    <= '0;
							held_q[0] <= '0;
							held_q[1] <= '0;
							held_q[2] <= '0;
						end
					end
				end
				bsc_pkg::S_RC: begin
					if (open_w) begin
						step_q <= 18'(ramp_new);
						ang_q  <= ang_open;
					end else begin
						torque_q <= 16'(ramp_new);
					end
				end
				bsc_pkg::S_DC: begin
					ang_q  <= ang_cl;
					step_q <= (torque_q >= 0) ? 18'sd16384 : -18'sd16384;
				end
				bsc_pkg::S_DUC: begin
					j_q   <= j_q + 2'd1;
					rej_q <= rej_q | rej_new;
					if (j_q == 2'd2 && !(rej_q | rej_new)) begin
						held_q[0] <= d_q[0];
						held_q[1] <= d_q[1];
						held_q[2] <= duty_new[12:0];
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		neg_q <= mul_neg;
		case (state_q)
			bsc_pkg::S_IDLE: enc_q <= encoder_angle;
			bsc_pkg::S_PC:   p_q   <= 16'(pcl);
			bsc_pkg::S_TC:   tgt_q <= 18'(r16);
			bsc_pkg::S_RC:   phase_q <= ang_open[15:0];
			bsc_pkg::S_AC:   amp_q <= 18'd4588 + 18'(r16);
			bsc_pkg::S_EC: begin
				aneg_q <= a_w[32];
				ma_q   <= a_w[32] ? 32'(-a_w) : 32'(a_w);
			end
			bsc_pkg::S_QC:   quo_q <= prod[bsc_pkg::RECIP_SHIFT +: 13];
			bsc_pkg::S_QMC:  r_q   <= 18'(ma_q - prod[31:0]);
			bsc_pkg::S_DC: begin
				phase_q <= phase_cl;
				amp_q   <= 18'(torque_q[15] ? -17'(torque_q) : 17'(torque_q)) + 18'd1311;
			end
			bsc_pkg::S_SPC:  s_q <= quad[1] ? -$signed(tval) : $signed(tval);
			bsc_pkg::S_DUC: begin
				if (j_q != 2'd2) d_q[j_q[0]] <= duty_new[12:0];
			end
			default: ;
		endcase
	end

`ifndef SYNTHESIS
	a_busy_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("result shown while input open");
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input open right after a transaction");
	a_idle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !drive_enable) |-> (u_duty == 13'd0 && v_duty == 13'd0
			&& w_duty == 13'd0 && !duty_rejected))
		else $error("idle result not zero");
	a_held_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> ($stable(u_duty) && $stable(duty_rejected)))
		else $error("result changed while stalled");
`endif

endmodule

FILE: design/bsc_mul.sv
// shared unsigned multiplier with registered product
module bsc_mul (
	input  logic                        clk,
	input  logic [bsc_pkg::MUL_AW-1:0]  a,
	input  logic [bsc_pkg::MUL_BW-1:0]  b,
	output logic [bsc_pkg::MUL_PW-1:0]  prod
);

	always_ff @(posedge clk) begin
		prod <= bsc_pkg::MUL_PW'(a) * bsc_pkg::MUL_PW'(b);
	end

endmodule
